/* hdl/mtp_pkg.sv */
`timescale 1ns / 1ps

package mtp_pkg;

  // Table geometry.
  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned TWIST_OFS   = 397;

  // Read position codes beyond the last table word, and the last word's index.
  localparam logic [IDX_W-1:0] POS_EXHAUSTED = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] POS_UNSEEDED  = IDX_W'(STATE_WORDS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX      = IDX_W'(STATE_WORDS - 1);

  // Generator constants.
  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] LCG_MULT     = 32'd69069;
  localparam logic [31:0] DEFAULT_SEED = 32'd4357;

  // Request type codes as they arrive on the port.
  localparam logic [1:0] REQ_GEN  = 2'd0;
  localparam logic [1:0] REQ_SEED = 2'd1;
  localparam logic [1:0] REQ_LOAD = 2'd2;

  // Command queue depth.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One classified request as it travels from the front to the engine.
  typedef struct packed {
    logic [1:0]       op;
    logic [31:0]      data;
    logic [IDX_W-1:0] index;
  } cmd_t;

endpackage

/* hdl/mtp_front.sv */
`timescale 1ns / 1ps

module mtp_front (
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              req_type_i,
  input  logic [31:0]             seed_value_i,
  input  logic [mtp_pkg::IDX_W-1:0] load_index_i,
  input  logic [31:0]             load_value_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output mtp_pkg::cmd_t           q_cmd_o
);
  import mtp_pkg::*;

  logic accept;
  logic keep;

  // A request is taken whenever the queue has room.
  assign busy   = q_full_i;
  assign accept = start && !q_full_i;

  // Reserved codes and loads beyond the table change nothing and are dropped here.
  always_comb begin
    case (req_type_i)
      REQ_GEN:  keep = 1'b1;
      REQ_SEED: keep = 1'b1;
      REQ_LOAD: keep = ({1'b0, load_index_i} < (IDX_W + 1)'(STATE_WORDS));
      default:  keep = 1'b0;
    endcase
  end

  // The data field carries the seed or the word to load.
  always_comb begin
    q_cmd_o.op    = req_type_i;
    q_cmd_o.data  = (req_type_i == REQ_SEED) ? seed_value_i : load_value_i;
    q_cmd_o.index = load_index_i;
  end

  assign q_push_o = accept && keep;

endmodule

/* hdl/mtp_fifo.sv */
`timescale 1ns / 1ps

module mtp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mtp_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mtp_pkg::cmd_t pop_cmd_o
);
  import mtp_pkg::*;

  cmd_t               entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o    = (count_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_cmd_o = entry_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* hdl/mtp_engine.sv */
`timescale 1ns / 1ps

module mtp_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  mtp_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          valid_o,
  output logic [31:0]   random_word_o
);
  import mtp_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SEED_A  = 4'd1;
  localparam logic [3:0] ST_SEED_B  = 4'd2;
  localparam logic [3:0] ST_TW_PRE  = 4'd3;
  localparam logic [3:0] ST_TW_LD   = 4'd4;
  localparam logic [3:0] ST_TW_RD   = 4'd5;
  localparam logic [3:0] ST_TW_WR   = 4'd6;
  localparam logic [3:0] ST_GEN_RD  = 4'd7;
  localparam logic [3:0] ST_GEN_OUT = 4'd8;

  logic [31:0] table_mem [STATE_WORDS];

  logic [3:0]       state_q, state_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             gen_q, gen_d;
  logic [31:0]      lcg_q, lcg_d;
  logic [31:0]      step_q, step_d;
  logic [15:0]      hi_q, hi_d;
  logic [31:0]      cur_q, cur_d;
  logic [31:0]      rd_a_q, rd_b_q;
  logic             valid_q;
  logic [31:0]      word_q;

  logic [IDX_W-1:0] addr_a, addr_b, wr_addr;
  logic [31:0]      wr_data;
  logic             wr_en, rd_en;
  logic [IDX_W:0]   far_sum;
  logic [31:0]      mul_in;
  logic [31:0]      mul_out;
  logic [31:0]      twist_y, twist_v;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Shared congruential multiplier, one product per cycle, kept to 32 bits.
  assign mul_in  = (state_q == ST_SEED_A) ? lcg_q : step_q;
  assign mul_out = mul_in * LCG_MULT + 32'd1;

  // Twist neighbours: the following word and the word a fixed offset ahead.
  assign far_sum = {1'b0, idx_q} + (IDX_W + 1)'(TWIST_OFS);
  always_comb begin
    if (far_sum >= (IDX_W + 1)'(STATE_WORDS)) begin
      addr_b = IDX_W'(far_sum - (IDX_W + 1)'(STATE_WORDS));
    end else begin
      addr_b = far_sum[IDX_W-1:0];
    end
  end

  always_comb begin
    case (state_q)
      ST_TW_PRE: addr_a = '0;
      ST_TW_RD:  addr_a = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
      default:   addr_a = pos_q;
    endcase
  end
  assign rd_en = (state_q == ST_TW_PRE) || (state_q == ST_TW_RD) || (state_q == ST_GEN_RD);

  // Recurrence for one word: upper bit of this word, lower bits of the next.
  assign twist_y = {cur_q[31], rd_a_q[30:0]};
  assign twist_v = rd_b_q ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : 32'd0);

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;

  // Sequencer for seeding, twisting, loading and output.
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    gen_d   = gen_q;
    lcg_d   = lcg_q;
    step_d  = step_q;
    hi_d    = hi_q;
    cur_d   = cur_q;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = twist_v;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          case (q_cmd_i.op)
            REQ_SEED: begin
              lcg_d   = q_cmd_i.data;
              idx_d   = '0;
              gen_d   = 1'b0;
              state_d = ST_SEED_A;
            end
            REQ_LOAD: begin
              wr_en   = 1'b1;
              wr_addr = q_cmd_i.index;
              wr_data = q_cmd_i.data;
              pos_d   = POS_EXHAUSTED;
            end
            default: begin
              if (pos_q == POS_UNSEEDED) begin
                lcg_d   = DEFAULT_SEED;
                idx_d   = '0;
                gen_d   = 1'b1;
                state_d = ST_SEED_A;
              end else if (pos_q == POS_EXHAUSTED) begin
                idx_d   = '0;
                state_d = ST_TW_PRE;
              end else begin
                state_d = ST_GEN_RD;
              end
            end
          endcase
        end
      end
      ST_SEED_A: begin
        hi_d    = lcg_q[31:16];
        step_d  = mul_out;
        state_d = ST_SEED_B;
      end
      ST_SEED_B: begin
        wr_en   = 1'b1;
        wr_data = {hi_q, step_q[31:16]};
        lcg_d   = mul_out;
        if (idx_q == LAST_IDX) begin
          pos_d = POS_EXHAUSTED;
          idx_d = '0;
          state_d = gen_q ? ST_TW_PRE : ST_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_SEED_A;
        end
      end
      ST_TW_PRE: begin
        state_d = ST_TW_LD;
      end
      ST_TW_LD: begin
        cur_d   = rd_a_q;
        state_d = ST_TW_RD;
      end
      ST_TW_RD: begin
        state_d = ST_TW_WR;
      end
      ST_TW_WR: begin
        wr_en = 1'b1;
        cur_d = rd_a_q;
        if (idx_q == LAST_IDX) begin
          pos_d   = '0;
          state_d = ST_GEN_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_TW_RD;
        end
      end
      ST_GEN_RD: begin
        state_d = ST_GEN_OUT;
      end
      ST_GEN_OUT: begin
        pos_d   = pos_q + 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= POS_UNSEEDED;
      idx_q   <= '0;
      gen_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      gen_q   <= gen_d;
      valid_q <= (state_q == ST_GEN_OUT);
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    lcg_q  <= lcg_d;
    step_q <= step_d;
    hi_q   <= hi_d;
    cur_q  <= cur_d;
    if (state_q == ST_GEN_OUT) begin
      word_q <= temper(rd_a_q);
    end
  end

  // State table: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= table_mem[addr_a];
      rd_b_q <= table_mem[addr_b];
    end
  end

  assign valid_o       = valid_q;
  assign random_word_o = word_q;

endmodule

/* hdl/mersenne_twister_prng_core.sv */
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+----------------------------------------
// request   | in        | start high, busy low | req_type_i, seed_value_i, load_index_i,
//           |           |                      | load_value_i
// result    | out       | valid_o, one cycle   | random_word_o
//
// A generate request from a live table passes ST_GEN_RD and ST_GEN_OUT in the engine;
// a load is written to the table from ST_IDLE. A seed request steps through ST_SEED_A
// and ST_SEED_B for each word, sharing the LCG multiplier. Regeneration reads each
// word's neighbours in ST_TW_RD and writes the word in ST_TW_WR.
// After reset the read position marks the table unseeded; the first generate seeds it unless a seed or load came first.
// Requests wait in a two-entry queue; busy is high only while that queue is full.
// The result strobe lasts one cycle and is never held back.

module mersenne_twister_prng_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                req_type_i,
  input  logic [31:0]               seed_value_i,
  input  logic [mtp_pkg::IDX_W-1:0] load_index_i,
  input  logic [31:0]               load_value_i,
  output logic                      valid_o,
  output logic [31:0]               random_word_o
);
  import mtp_pkg::*;

  logic q_full, q_push, q_pop, q_empty;
  cmd_t push_cmd, pop_cmd;

  // Request intake and classification.
  mtp_front u_front (
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .seed_value_i (seed_value_i),
    .load_index_i (load_index_i),
    .load_value_i (load_value_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  // Short queue between intake and engine.
  mtp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (pop_cmd)
  );

  // Table engine: seeding, twisting, loading and tempering.
  mtp_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_cmd_i       (pop_cmd),
    .q_pop_o       (q_pop),
    .valid_o       (valid_o),
    .random_word_o (random_word_o)
  );

endmodule
